@@ rtl/gftj_pkg.sv @@
// Shared constants of the greedy full text justifier.
`default_nettype none
package gftj_pkg;
  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_EOW  = 2'd1;
  localparam logic [1:0] CMD_EOT  = 2'd2;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
endpackage
`default_nettype wire

@@ rtl/gftj_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module gftj_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/greedy_full_text_justifier_core.sv @@
// Top level of the greedy full text justifier: sequencer, stores and divider.
// Usage:
//   s_axis carries one input item per transfer: tdata[1:0] command, [9:2] ch.
//   m_axis carries one line character per transfer: tdata out_char,
//   tlast on the final character of a line, tuser word_too_long.
//   cfg_we_i/cfg_wdata_i write line_width while the block is idle.
// Timing:
//   A word character is taken into the word store. An end of word that keeps
//   the line copies the word into the line store through the registered RAM
//   read, each character passing S_WCOPY_RD and then S_WCOPY_WR.
//   Emitting a full line first runs a one-bit-per-cycle restoring divider for
//   the space spread, then walks the line store: each stored character passes
//   S_EM_RD, S_EM_WAIT and S_EM_OUT, each gap adds S_EM_SP for its spaces,
//   S_PAD pads, S_AFTER closes the line; a stalled receiver holds the walk.
//   The word is copied after the emit. s_axis_tready is low meanwhile.
// Reset clears all control state; the stores need no clearing.
`default_nettype none
module greedy_full_text_justifier_core #(
  parameter int MaxWidth = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // command[1:0], ch[9:2], zeros
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_char[7:0]
  output logic             m_axis_tlast,
  output logic             m_axis_tuser    // word_too_long
);
  localparam int AW = $clog2(MaxWidth);
  localparam int CW = $clog2(MaxWidth + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WCOPY_RD, S_WCOPY_WR, S_DIV, S_EM_RD, S_EM_WAIT, S_EM_OUT,
    S_EM_SP, S_PAD, S_AFTER
  } state_e;

  state_e     state_q;
  logic [6:0] width_q;
  logic [CW-1:0] eff_w;
  logic [CW-1:0] line_len_q, word_len_q, n_q, i_q, out_n_q, cpy_q, base_q;
  logic [CW-1:0] rem_q, k_q, sp_q, dividend_q;
  logic [AW-1:0] gap_q;
  logic       ovf_q, cut_q, seen_q, emitted_q, spread_q, post_copy_q, pend_ovf_q;
  logic [2:0] div_cnt_q;

  logic          lw_we, ww_we;
  logic [AW-1:0] lw_addr, lr_addr, ww_addr, wr_addr;
  logic [8:0]    lw_data, lr_data;
  logic [7:0]    wr_data;
  logic [CW-1:0] n_now;
  logic          join_ok;
  logic          out_load;

  always_comb begin
    if (width_q == 7'd0) eff_w = CW'(1);
    else if ({1'b0, width_q} > 8'(MaxWidth)) eff_w = CW'(MaxWidth);
    else eff_w = CW'(width_q);
  end

  gftj_ram #(.Width(9), .Depth(MaxWidth)) u_line (
    .clk_i, .we_i(lw_we), .waddr_i(lw_addr), .wdata_i(lw_data),
    .raddr_i(lr_addr), .rdata_o(lr_data));
  gftj_ram #(.Width(8), .Depth(MaxWidth)) u_word (
    .clk_i, .we_i(ww_we), .waddr_i(ww_addr), .wdata_i(s_axis_tdata[9:2]),
    .raddr_i(wr_addr), .rdata_o(wr_data));

  wire s_fire = s_axis_tvalid && s_axis_tready;
  wire m_fire = m_axis_tvalid && m_axis_tready;
  wire [1:0] cmd = s_axis_tdata[1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign ww_we   = s_fire && cmd == gftj_pkg::CMD_CHAR && word_len_q < eff_w;
  assign ww_addr = word_len_q[AW-1:0];
  assign wr_addr = cpy_q[AW-1:0];
  assign lr_addr = i_q[AW-1:0];

  assign n_now = (word_len_q > eff_w) ? eff_w : word_len_q;
  // The closed word joins the current line with one space.
  assign join_ok = line_len_q != '0 &&
                   (CW+1)'(line_len_q) + (CW+1)'(1) + (CW+1)'(n_now) <= (CW+1)'(eff_w);

  // Line write: gap mark on join, then word characters from the copy walk.
  always_comb begin
    lw_we = 1'b0;
    lw_addr = line_len_q[AW-1:0];
    lw_data = {1'b0, wr_data};
    if (state_q == S_WCOPY_WR) lw_we = 1'b1;
    else if (s_fire && cmd == gftj_pkg::CMD_EOW && word_len_q != '0 && join_ok) begin
      lw_we = 1'b1;
      lw_data = {1'b1, gftj_pkg::SPACE_CHAR};
    end
  end

  // Load the output register when a character is ready and the slot is free.
  always_comb begin
    out_load = 1'b0;
    if (!m_axis_tvalid || m_fire) begin
      unique case (state_q)
        S_EM_OUT: out_load = !lr_data[8];
        S_EM_SP:  out_load = sp_q != '0 && out_n_q < eff_w;
        S_PAD:    out_load = out_n_q < eff_w;
        default:  out_load = 1'b0;
      endcase
    end
  end

  wire            em_more = (i_q < line_len_q) && (out_n_q < eff_w);
  wire [CW:0]     div_try = {rem_q, dividend_q[CW-1]} - {1'b0, CW'(gap_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; width_q <= 7'd64; line_len_q <= '0; word_len_q <= '0;
      gap_q <= '0; ovf_q <= 1'b0; cut_q <= 1'b0; seen_q <= 1'b0;
      emitted_q <= 1'b0; m_axis_tvalid <= 1'b0; post_copy_q <= 1'b0;
      n_q <= '0; i_q <= '0; out_n_q <= '0; cpy_q <= '0; base_q <= '0;
      rem_q <= '0; k_q <= '0; sp_q <= '0; dividend_q <= '0; spread_q <= 1'b0;
      div_cnt_q <= '0; pend_ovf_q <= 1'b0; m_axis_tdata <= '0;
      m_axis_tlast <= 1'b0; m_axis_tuser <= 1'b0;
    end else begin
      if (cfg_we_i) width_q <= cfg_wdata_i;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_fire) m_axis_tvalid <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_fire) begin
          unique case (cmd)
            gftj_pkg::CMD_CHAR: if (word_len_q < eff_w) word_len_q <= word_len_q + 1'b1;
              else cut_q <= 1'b1;
            gftj_pkg::CMD_EOW: begin
              seen_q <= 1'b1; word_len_q <= '0; cut_q <= 1'b0;
              n_q <= n_now; pend_ovf_q <= cut_q || (word_len_q > eff_w);
              cpy_q <= '0;
              if (word_len_q == '0) begin
              end else if (join_ok) begin
                line_len_q <= line_len_q + 1'b1; gap_q <= gap_q + 1'b1;
                state_q <= S_WCOPY_RD;
              end else if (line_len_q != '0) begin
                post_copy_q <= 1'b1;
                spread_q <= gap_q != '0 && line_len_q <= eff_w;
                dividend_q <= eff_w - line_len_q; rem_q <= '0; base_q <= '0;
                div_cnt_q <= 3'(CW - 1); state_q <= S_DIV;
              end else begin
                ovf_q <= cut_q || (word_len_q > eff_w); gap_q <= '0;
                state_q <= S_WCOPY_RD;
              end
            end
            gftj_pkg::CMD_EOT: begin
              word_len_q <= '0; cut_q <= 1'b0;
              if (line_len_q != '0 || (seen_q && !emitted_q)) begin
                post_copy_q <= 1'b0; spread_q <= 1'b0; i_q <= '0; out_n_q <= '0;
                k_q <= '0; state_q <= S_EM_RD;
              end else begin
                seen_q <= 1'b0; emitted_q <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          // Restoring division of spare room by gap count, one bit a cycle.
          dividend_q <= dividend_q << 1;
          if (!div_try[CW]) begin
            rem_q <= div_try[CW-1:0]; base_q <= {base_q[CW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[CW-2:0], dividend_q[CW-1]}; base_q <= base_q << 1;
          end
          if (div_cnt_q == '0) begin
            i_q <= '0; out_n_q <= '0; k_q <= '0; state_q <= S_EM_RD;
          end else div_cnt_q <= div_cnt_q - 1'b1;
        end
        S_EM_RD: begin
          if (em_more) state_q <= S_EM_WAIT;
          else state_q <= S_PAD;
        end
        S_EM_WAIT: state_q <= S_EM_OUT;
        S_EM_OUT: if (!m_axis_tvalid || m_fire) begin
          if (lr_data[8]) begin
            sp_q <= spread_q ? (CW'(1) + base_q + ((k_q < rem_q) ? CW'(1) : CW'(0)))
                             : CW'(1);
            k_q <= k_q + 1'b1; state_q <= S_EM_SP;
          end else begin
            m_axis_tdata <= lr_data[7:0];
            m_axis_tlast <= (out_n_q + 1'b1 == eff_w); m_axis_tuser <= ovf_q;
            out_n_q <= out_n_q + 1'b1; i_q <= i_q + 1'b1; state_q <= S_EM_RD;
          end
        end
        S_EM_SP: if (!m_axis_tvalid || m_fire) begin
          if (sp_q == '0 || out_n_q >= eff_w) begin
            i_q <= i_q + 1'b1; state_q <= S_EM_RD;
          end else begin
            m_axis_tdata <= gftj_pkg::SPACE_CHAR;
            m_axis_tlast <= (out_n_q + 1'b1 == eff_w); m_axis_tuser <= ovf_q;
            out_n_q <= out_n_q + 1'b1; sp_q <= sp_q - 1'b1;
          end
        end
        S_PAD: if (!m_axis_tvalid || m_fire) begin
          if (out_n_q >= eff_w) state_q <= S_AFTER;
          else begin
            m_axis_tdata <= gftj_pkg::SPACE_CHAR;
            m_axis_tlast <= (out_n_q + 1'b1 == eff_w); m_axis_tuser <= ovf_q;
            out_n_q <= out_n_q + 1'b1;
          end
        end
        S_AFTER: begin
          line_len_q <= '0; gap_q <= '0;
          if (post_copy_q) begin
            emitted_q <= 1'b1; ovf_q <= pend_ovf_q; post_copy_q <= 1'b0;
            cpy_q <= '0; state_q <= S_WCOPY_RD;
          end else begin
            ovf_q <= 1'b0; seen_q <= 1'b0; emitted_q <= 1'b0; state_q <= S_IDLE;
          end
        end
        S_WCOPY_RD: begin
          if (cpy_q >= n_q) state_q <= S_IDLE;
          else state_q <= S_WCOPY_WR;
        end
        S_WCOPY_WR: begin
          line_len_q <= line_len_q + 1'b1; cpy_q <= cpy_q + 1'b1;
          state_q <= S_WCOPY_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready || state_q == S_IDLE)
    else $error("input taken mid line");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_len_q <= CW'(MaxWidth)) else $error("line overrun");
endmodule
`default_nettype wire

@@ verif/tb_greedy_full_text_justifier_core.sv @@
// Self-checking testbench of the greedy full text justifier core.
`timescale 1ns / 100ps
module tb_greedy_full_text_justifier_core;

  localparam int MAX_W = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       too_long;
  } line_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  greedy_full_text_justifier_core #(.MaxWidth(MAX_W)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [6:0]  width_reg;
  logic [8:0]  line_mem [MAX_W];
  logic [7:0]  word_mem [MAX_W];
  int          line_len, gaps, word_len;
  bit          ovf, cut, seen_word, line_out;

  line_char_t  expected_chars [$];
  int          mismatches, lines_seen, items_sent;
  bit          send_idle, recv_idle;
  int          hold_cycles;

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic void emit_line(bit justify);
    int w, n, k, base, more, s;
    bit spread;
    logic [7:0] buf_c [MAX_W];
    line_char_t c;
    w = eff_width();
    n = 0; k = 0; base = 0; more = 0;
    spread = justify && gaps > 0 && line_len <= w;
    if (spread) begin
      base = (w - line_len) / gaps;
      more = (w - line_len) % gaps;
    end
    for (int i = 0; i < line_len && i < MAX_W && n < w; i++) begin
      if (line_mem[i][8]) begin
        s = 1;
        if (spread) s = 1 + base + ((k < more) ? 1 : 0);
        k++;
        for (int t = 0; t < s && n < w; t++) buf_c[n++] = gftj_pkg::SPACE_CHAR;
      end else begin
        buf_c[n++] = line_mem[i][7:0];
      end
    end
    while (n < w) buf_c[n++] = gftj_pkg::SPACE_CHAR;
    for (int i = 0; i < w; i++) begin
      c.ch = buf_c[i];
      c.last = (i + 1 == w);
      c.too_long = ovf;
      expected_chars = {expected_chars, c};
    end
    line_len = 0; gaps = 0; ovf = 0; line_out = 1;
  endfunction

  function automatic void close_word();
    int w, n;
    bit was_cut;
    w = eff_width();
    n = word_len;
    was_cut = cut;
    seen_word = 1; word_len = 0; cut = 0;
    if (n == 0) return;
    if (n > w) begin
      n = w;
      was_cut = 1;
    end
    if (line_len > 0 && line_len + 1 + n <= w) begin
      line_mem[line_len++] = {1'b1, gftj_pkg::SPACE_CHAR};
      for (int i = 0; i < n; i++) line_mem[line_len++] = {1'b0, word_mem[i]};
      gaps++;
      return;
    end
    if (line_len > 0) emit_line(1);
    for (int i = 0; i < n; i++) line_mem[i] = {1'b0, word_mem[i]};
    line_len = n; gaps = 0; ovf = was_cut;
  endfunction

  function automatic void predict_item(logic [1:0] cmd, logic [7:0] ch);
    case (cmd)
      gftj_pkg::CMD_CHAR: begin
        if (word_len < eff_width() && word_len < MAX_W) word_mem[word_len++] = ch;
        else cut = 1;
      end
      gftj_pkg::CMD_EOW: close_word();
      gftj_pkg::CMD_EOT: begin
        if (line_len > 0 || (seen_word && !line_out)) emit_line(0);
        line_len = 0; gaps = 0; word_len = 0;
        ovf = 0; cut = 0; seen_word = 0; line_out = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [7:0] ch);
    int gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, ch, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(cmd, ch);
    items_sent++;
  endtask

  task automatic send_word(string w);
    for (int i = 0; i < w.len(); i++) send_item(gftj_pkg::CMD_CHAR, w[i]);
    send_item(gftj_pkg::CMD_EOW, 8'h00);
  endtask

  task automatic send_rand_word(int len);
    for (int i = 0; i < len; i++)
      send_item(gftj_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
    send_item(gftj_pkg::CMD_EOW, 8'h00);
  endtask

  task automatic drain_and_set_width(logic [6:0] w);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_chars.size() != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg = w;
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= $urandom_range(1, 15);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    line_char_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: char %h", m_axis_tdata);
      end else begin
        e = expected_chars.pop_front();
        if (e.ch !== m_axis_tdata || e.last !== m_axis_tlast ||
            e.too_long !== m_axis_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp char %h last %b flag %b, got %h %b %b",
                     e.ch, e.last, e.too_long, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
        if (m_axis_tlast) lines_seen++;
      end
    end
  end

  task automatic test_directed();
    drain_and_set_width(7'd16);
    send_word("the"); send_word("quick"); send_word("brown");
    send_word("fox"); send_word("jumps"); send_word("over");
    send_item(gftj_pkg::CMD_EOT, 8'h00);
    send_item(gftj_pkg::CMD_EOT, 8'h00);                   // empty text
    send_item(gftj_pkg::CMD_EOW, 8'h00); send_item(gftj_pkg::CMD_EOW, 8'h00);
    send_item(gftj_pkg::CMD_EOT, 8'h00);                   // only empty words
    send_word("abcdefghijklmnopqrstu");                    // too long
    send_word("x");
    send_item(gftj_pkg::CMD_CHAR, 8'hff); send_item(gftj_pkg::CMD_CHAR, 8'h00);
    send_item(2'd3, 8'h55);                                // unknown command
    send_item(gftj_pkg::CMD_EOT, 8'h00);                   // unfinished word dropped
  endtask

  task automatic test_widths();
    logic [6:0] widths [5] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd2};
    foreach (widths[j]) begin
      drain_and_set_width(widths[j]);
      send_word("ab"); send_word("c"); send_rand_word(3);
      send_item(gftj_pkg::CMD_EOT, 8'h00);
    end
  endtask

  task automatic test_width_change_mid_line();
    drain_and_set_width(7'd30);
    send_word("aaaaaaaaaa"); send_word("bbbbbbbbbb");
    send_item(gftj_pkg::CMD_CHAR, 8'h41); send_item(gftj_pkg::CMD_CHAR, 8'h42);
    drain_and_set_width(7'd8);
    send_item(gftj_pkg::CMD_EOW, 8'h00); send_word("cc");
    send_item(gftj_pkg::CMD_EOT, 8'h00);
  endtask

  task automatic test_backpressure();
    drain_and_set_width(7'd12);
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) send_rand_word($urandom_range(1, 6));
    send_item(gftj_pkg::CMD_EOT, 8'h00);
  endtask

  task automatic test_random(int target);
    int stop, r;
    stop = items_sent + target;
    while (items_sent < stop) begin
      if (items_sent > stop - 60) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if ($urandom_range(0, 9) == 0)
        drain_and_set_width(7'($urandom_range(0, 20) == 0 ? $urandom_range(0, 127)
                                                         : $urandom_range(1, 20)));
      r = $urandom_range(0, 19);
      if (r == 0) send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      else if (r < 3) send_item(gftj_pkg::CMD_EOT, 8'h00);
      else send_rand_word($urandom_range(0, 3) == 0 ? $urandom_range(0, 24)
                                                    : $urandom_range(1, 6));
    end
    send_item(gftj_pkg::CMD_EOT, 8'h00);
  endtask

  initial begin
    width_reg = 7'd64;
    line_len = 0; gaps = 0; word_len = 0;
    ovf = 0; cut = 0; seen_word = 0; line_out = 0;
    mismatches = 0; lines_seen = 0; items_sent = 0; hold_cycles = 0;
    send_idle = 1; recv_idle = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_widths();
    test_width_change_mid_line();
    test_backpressure();
    test_random(140);
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d input items and %0d lines over widths 0..127,", items_sent,
             lines_seen);
    $display("including empty words, long words, empty texts and a long output stall");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("greedy_full_text_justifier_core: match");
    end else begin
      $display("greedy_full_text_justifier_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("greedy_full_text_justifier_core: mismatch");
    $finish;
  end
endmodule

@@ files.f @@
rtl/gftj_pkg.sv
rtl/gftj_ram.sv
rtl/greedy_full_text_justifier_core.sv
verif/tb_greedy_full_text_justifier_core.sv
